FILE: rtl/gds_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_pkg: shared types and constants for grouped depth statistics
// Field widths, accumulator snapshot and the fixed-point helpers.
// ----------------------------------------------------------------------------
package gds_pkg;

  localparam int TagW   = 16;
  localparam int DepthW = 16;
  localparam int CountW = 24;
  localparam int SumW   = 40;
  localparam int SqW    = 56;
  localparam int FracW  = 16;

  // arithmetic unit widths
  localparam int ProdW  = 80;   // n*Q, S*S, K*sd
  localparam int RadW   = 112;  // V * 2^(2F)
  localparam int RootW  = 56;
  localparam int DenW   = 40;
  localparam int SdataW = 32;
  localparam int MdataW = 192;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  // round(1.96 * 2^16)
  localparam logic [16:0] KConst = 17'd128451;

  // closed group as handed from the front end to the back end
  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [CountW-1:0] n;
    logic [SumW-1:0]   s;
    logic [SqW-1:0]    q;
    logic [CountW-1:0] z;
    logic              sat;
  } snap_t;

  // saturate a quotient to 32 bits
  function automatic logic [31:0] sat32(input logic [ProdW-1:0] v);
    sat32 = (|v[ProdW-1:32]) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // saturate a quotient to 17 bits
  function automatic logic [16:0] sat17(input logic [ProdW-1:0] v);
    sat17 = (|v[ProdW-1:17]) ? 17'h1FFFF : v[16:0];
  endfunction

endpackage

FILE: rtl/gds_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_front: group accumulator
// Takes one word a cycle while accept is high, accumulates the open group
// and hands a snapshot of a closed group to the queue.
// ----------------------------------------------------------------------------
module gds_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    accept,
  input  logic                    flush,
  input  logic [15:0]             tag_in,
  input  logic [15:0]             depth_in,
  output logic                    push,
  output gds_pkg::snap_t          snap
);
  import gds_pkg::*;

  logic [TagW-1:0]   cur, cur_next;
  logic              open, open_next;
  logic [CountW-1:0] cnt, cnt_next;
  logic [SumW-1:0]   sum, sum_next;
  logic [SqW-1:0]    sq, sq_next;
  logic [CountW-1:0] nz, nz_next;
  logic              sat, sat_next;
  logic              close;
  logic [31:0]       dd;

  // group close on flush or tag change
  assign close = open && (flush || (tag_in != cur));
  assign push  = accept && close;
  assign dd    = depth_in * depth_in;

  assign snap.tag = cur;
  assign snap.n   = cnt;
  assign snap.s   = sum;
  assign snap.q   = sq;
  assign snap.z   = nz;
  assign snap.sat = sat;

  // accumulator update
  always_comb begin
    cur_next  = cur;
    open_next = open;
    cnt_next  = cnt;
    sum_next  = sum;
    sq_next   = sq;
    nz_next   = nz;
    sat_next  = sat;
    if (accept) begin
      if (close) begin
        open_next = 1'b0;
        cnt_next  = '0;
        sum_next  = '0;
        sq_next   = '0;
        nz_next   = '0;
        sat_next  = 1'b0;
      end
      if (!flush) begin
        if (!open || close) begin
          open_next = 1'b1;
          cur_next  = tag_in;
        end
        if (cnt_next == CountMax) begin
          sat_next = 1'b1;
        end else begin
          cnt_next = cnt_next + 1'b1;
          sum_next = sum_next + {{(SumW-DepthW){1'b0}}, depth_in};
          sq_next  = sq_next + {{(SqW-32){1'b0}}, dd};
          if (depth_in != '0) begin
            nz_next = nz_next + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur  <= '0;
      open <= 1'b0;
      cnt  <= '0;
      sum  <= '0;
      sq   <= '0;
      nz   <= '0;
      sat  <= 1'b0;
    end else begin
      cur  <= cur_next;
      open <= open_next;
      cnt  <= cnt_next;
      sum  <= sum_next;
      sq   <= sq_next;
      nz   <= nz_next;
      sat  <= sat_next;
    end
  end

`ifndef ASSERT_OFF
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    open == (cnt != '0))
    else $error("open flag and sample count disagree");
  a_nz_le_n: assert property (@(posedge clk) disable iff (rst)
    nz <= cnt)
    else $error("nonzero count above sample count");
  a_push_open: assert property (@(posedge clk) disable iff (rst)
    accept && flush && open |=> !open)
    else $error("group still open after flush");
`endif

endmodule

FILE: rtl/gds_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_queue: two-entry snapshot queue
// Decouples the accumulator from the statistics sequencer.
// ----------------------------------------------------------------------------
module gds_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gds_pkg::snap_t wdata,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output gds_pkg::snap_t rdata
);
  import gds_pkg::*;

  snap_t       mem [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign rdata      = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef ASSERT_OFF
  a_count: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue count out of range");
  a_no_over: assert property (@(posedge clk) disable iff (rst)
    full |-> !push || pop)
    else $error("push into full queue");
  a_no_under: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/gds_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gds_back: statistics sequencer
// Serial multiplier, bit-pair square root and restoring divider, stepped
// through the statistics of one closed group; result held in an output word.
// ----------------------------------------------------------------------------
module gds_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  gds_pkg::snap_t head,
  output logic           pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [191:0]   m_tdata,
  output logic [1:0]     m_tuser
);
  import gds_pkg::*;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_MUL_NQ   = 4'd1;
  localparam logic [3:0] S_MUL_SS   = 4'd2;
  localparam logic [3:0] S_SQ_V     = 4'd3;
  localparam logic [3:0] S_SQ_N     = 4'd4;
  localparam logic [3:0] S_DIV_SD   = 4'd5;
  localparam logic [3:0] S_MUL_K    = 4'd6;
  localparam logic [3:0] S_DIV_ERR  = 4'd7;
  localparam logic [3:0] S_DIV_MEAN = 4'd8;
  localparam logic [3:0] S_DIV_CV   = 4'd9;
  localparam logic [3:0] S_DIV_COV  = 4'd10;
  localparam logic [3:0] S_DONE     = 4'd11;

  localparam logic [6:0] MulLast = 7'd55;
  localparam logic [6:0] SqLast  = 7'd55;
  localparam logic [6:0] DivLast = 7'd79;

  logic [3:0]  state;
  logic        first;
  logic [6:0]  cnt;
  snap_t       g;

  // unit registers
  logic [ProdW-1:0] m_acc, m_a;
  logic [SqW-1:0]   m_b;
  logic [RadW-1:0]  q_rad;
  logic [57:0]      q_rem;
  logic [RootW-1:0] q_root;
  logic [ProdW-1:0] d_num;
  logic [DenW-1:0]  d_den, d_rem;

  // intermediate results
  logic [ProdW-1:0] nq, ss, ksd;
  logic [RootW-1:0] root_v, sd;
  logic [27:0]      root_n;
  logic [31:0]      err_r, mean_r, sd_r, cv_r;
  logic [16:0]      cov_r;

  // one step of each unit
  logic [ProdW-1:0] m_acc_next;
  logic [57:0]      q_rs, q_tr, q_rem_next;
  logic             q_ge;
  logic [RootW-1:0] q_root_next;
  logic [DenW:0]    d_rs;
  logic             d_ge;
  logic [DenW-1:0]  d_rem_next;
  logic [ProdW-1:0] d_num_next;
  logic [ProdW-1:0] vv;

  assign m_acc_next  = m_b[0] ? m_acc + m_a : m_acc;
  assign q_rs        = {q_rem[55:0], q_rad[RadW-1:RadW-2]};
  assign q_tr        = {q_root, 2'b01};
  assign q_ge        = (q_rs >= q_tr);
  assign q_rem_next  = q_ge ? q_rs - q_tr : q_rs;
  assign q_root_next = {q_root[RootW-2:0], q_ge};
  assign d_rs        = {d_rem, d_num[ProdW-1]};
  assign d_ge        = (d_rs >= {1'b0, d_den});
  assign d_rem_next  = d_ge ? DenW'(d_rs - {1'b0, d_den}) : d_rs[DenW-1:0];
  assign d_num_next  = {d_num[ProdW-2:0], d_ge};
  assign vv          = (nq > ss) ? nq - ss : '0;

  assign pop = (state == S_IDLE) && head_valid;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      first    <= 1'b1;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      // output word valid
      if (state == S_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (head_valid) begin
            g     <= head;
            state <= S_MUL_NQ;
            first <= 1'b1;
          end
        end
        S_MUL_NQ, S_MUL_SS, S_MUL_K: begin
          if (first) begin
            first <= 1'b0;
            cnt   <= '0;
            m_acc <= '0;
            if (state == S_MUL_NQ) begin
              m_a <= {{(ProdW-CountW){1'b0}}, g.n};
              m_b <= g.q;
            end else if (state == S_MUL_SS) begin
              m_a <= {{(ProdW-SumW){1'b0}}, g.s};
              m_b <= {{(SqW-SumW){1'b0}}, g.s};
            end else begin
              m_a <= {{(ProdW-RootW){1'b0}}, sd};
              m_b <= {{(SqW-17){1'b0}}, KConst};
            end
          end else begin
            m_acc <= m_acc_next;
            m_a   <= {m_a[ProdW-2:0], 1'b0};
            m_b   <= {1'b0, m_b[SqW-1:1]};
            cnt   <= cnt + 1'b1;
            if (cnt == MulLast) begin
              first <= 1'b1;
              if (state == S_MUL_NQ) begin
                nq    <= m_acc_next;
                state <= S_MUL_SS;
              end else if (state == S_MUL_SS) begin
                ss    <= m_acc_next;
                state <= S_SQ_V;
              end else begin
                ksd   <= m_acc_next;
                state <= S_DIV_ERR;
              end
            end
          end
        end
        S_SQ_V, S_SQ_N: begin
          if (first) begin
            first  <= 1'b0;
            cnt    <= '0;
            q_rem  <= '0;
            q_root <= '0;
            if (state == S_SQ_V) begin
              q_rad <= {vv, {(2*FracW){1'b0}}};
            end else begin
              q_rad <= {{(RadW-CountW-2*FracW){1'b0}}, g.n, {(2*FracW){1'b0}}};
            end
          end else begin
            q_rem  <= q_rem_next;
            q_root <= q_root_next;
            q_rad  <= {q_rad[RadW-3:0], 2'b00};
            cnt    <= cnt + 1'b1;
            if (cnt == SqLast) begin
              first <= 1'b1;
              if (state == S_SQ_V) begin
                root_v <= q_root_next;
                state  <= S_SQ_N;
              end else begin
                root_n <= q_root_next[27:0];
                state  <= S_DIV_SD;
              end
            end
          end
        end
        S_DIV_SD, S_DIV_ERR, S_DIV_MEAN, S_DIV_CV, S_DIV_COV: begin
          if (first) begin
            // cv undefined for a zero sum: skip the divide
            if (state == S_DIV_CV && g.s == '0) begin
              cv_r  <= '0;
              state <= S_DIV_COV;
            end else begin
              first <= 1'b0;
              cnt   <= '0;
              d_rem <= '0;
              case (state)
                S_DIV_SD: begin
                  d_num <= {{(ProdW-RootW){1'b0}}, root_v};
                  d_den <= {{(DenW-CountW){1'b0}}, g.n};
                end
                S_DIV_ERR: begin
                  d_num <= ksd;
                  d_den <= {{(DenW-28){1'b0}}, root_n};
                end
                S_DIV_MEAN: begin
                  d_num <= {{(ProdW-SumW-FracW){1'b0}}, g.s, {FracW{1'b0}}};
                  d_den <= {{(DenW-CountW){1'b0}}, g.n};
                end
                S_DIV_CV: begin
                  d_num <= {{(ProdW-RootW){1'b0}}, root_v};
                  d_den <= g.s;
                end
                default: begin
                  d_num <= {{(ProdW-CountW-16){1'b0}}, g.z, 16'h0000};
                  d_den <= {{(DenW-CountW){1'b0}}, g.n};
                end
              endcase
            end
          end else begin
            d_rem <= d_rem_next;
            d_num <= d_num_next;
            cnt   <= cnt + 1'b1;
            if (cnt == DivLast) begin
              first <= 1'b1;
              case (state)
                S_DIV_SD: begin
                  sd    <= d_num_next[RootW-1:0];
                  sd_r  <= sat32(d_num_next);
                  state <= S_MUL_K;
                end
                S_DIV_ERR: begin
                  err_r <= sat32(d_num_next);
                  state <= S_DIV_MEAN;
                end
                S_DIV_MEAN: begin
                  mean_r <= sat32(d_num_next);
                  state  <= S_DIV_CV;
                end
                S_DIV_CV: begin
                  cv_r  <= sat32(d_num_next);
                  state <= S_DIV_COV;
                end
                default: begin
                  cov_r <= sat17(d_num_next);
                  state <= S_DONE;
                end
              endcase
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tdata  <= {7'd0, cov_r, cv_r, err_r, sd_r, mean_r, g.n, g.tag};
            m_tuser  <= {g.sat, (g.s != '0)};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= DivLast + 7'd1)
    else $error("iteration counter out of range");
  a_den: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV_SD || state == S_DIV_ERR || state == S_DIV_MEAN ||
     state == S_DIV_CV || state == S_DIV_COV) && !first |-> d_den != '0)
    else $error("divide by zero");
  a_sqrt_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQ_V || state == S_SQ_N) && !first |->
      q_rem <= {1'b0, q_root, 1'b0})
    else $error("square root remainder too large");
`endif

endmodule

FILE: rtl/grouped_depth_statistics_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_depth_statistics_top: per-group depth mean, sd and coverage
// Accumulates tagged depth samples and reports Q16.16 statistics per group.
// ----------------------------------------------------------------------------
// Samples are taken one word per cycle while the two-entry group queue has
// room; a tag change or a flush closes the group and queues its totals. Each
// closed group then runs through the statistics sequencer: three 56-step
// serial multiplies, two 56-step square roots and five 80-step divides
// (cv skipped on a zero sum), in turn on the shared units. Sample input stalls
// only when two closed groups already wait behind the one being computed.
module grouped_depth_statistics_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [31:0]  s_tdata,   // group_tag[15:0], depth[31:16]
  input  logic         s_tuser,   // command: 0 sample, 1 flush
  output logic         m_tvalid,
  input  logic         m_tready,
  // group_id, positions, mean_q16, sd_q16, error95_q16, cv_q16, covered_q16
  output logic [191:0] m_tdata,
  output logic [1:0]   m_tuser    // cv_valid, overflow
);
  import gds_pkg::*;

  logic  accept, push, full, pop, head_valid;
  snap_t snap, head;

  assign s_tready = !full;
  assign accept   = s_tvalid && s_tready;

  // accumulator front end
  gds_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .flush    (s_tuser),
    .tag_in   (s_tdata[15:0]),
    .depth_in (s_tdata[31:16]),
    .push     (push),
    .snap     (snap)
  );

  // closed group queue
  gds_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .wdata      (snap),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .rdata      (head)
  );

  // statistics back end
  gds_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule
